// File: hw/rtl/page_permission_region_update_macros.svh
// ----------------------------------------------------------------------------
// page permission region update assertion macros
// shared property wrappers for the rtl checks
// ----------------------------------------------------------------------------
`ifndef PAGE_PERMISSION_REGION_UPDATE_MACROS_SVH
`define PAGE_PERMISSION_REGION_UPDATE_MACROS_SVH

// same-cycle implication, off during reset
`define PPRU_ASSERT_ALWAYS(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppru check failed");

// next-cycle implication, off during reset
`define PPRU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppru check failed");

`endif

// File: hw/rtl/ppru_pkg.sv
// ----------------------------------------------------------------------------
// ppru_pkg
// shared types and constants of the page permission region update block
// ----------------------------------------------------------------------------
package ppru_pkg;

   localparam int ENTRIES_PER_TABLE = 512;
   localparam int PAGE_IDX_MAX_W    = 15;   // up to 64 tables of 512 pages
   localparam int PAGE_CNT_MAX_W    = 16;
   localparam int ADDR_W            = 48;
   localparam int PAGE_NUM_W        = ADDR_W - 12;
   localparam int ENTRY_W           = 24;
   localparam int PAGES_W           = 13;
   localparam int FLAGS_W           = 3;
   localparam int USER_FLOOR_PAGE   = 256;  // 1 MiB in 4 KiB pages
   localparam logic [PAGES_W-1:0] PAGES_SAT = 13'h1FFF;

   // flag bit positions
   localparam int FLAG_PRESENT  = 0;
   localparam int FLAG_WRITABLE = 1;
   localparam int FLAG_USER     = 2;

   typedef enum logic [1:0] {
      OP_MARK_USER  = 2'd0,
      OP_MARK_SUPER = 2'd1,
      OP_READ       = 2'd2,
      OP_RSVD       = 2'd3
   } op_type;

   // page range worked out for one request
   typedef struct packed {
      op_type                    op;
      logic                      empty;
      logic                      in_range;
      logic [PAGE_IDX_MAX_W-1:0] first;
      logic [PAGE_CNT_MAX_W-1:0] count;
      logic [PAGES_W-1:0]        pages;
   } plan_type;

   typedef struct packed {
      logic [PAGES_W-1:0] pages_touched;
      logic               in_range;
      logic [ENTRY_W-1:0] entry_value;
   } rsp_type;

   function automatic logic [FLAGS_W-1:0] flags_update(
      input logic [FLAGS_W-1:0] flags,
      input logic               to_user
   );
      logic [FLAGS_W-1:0] f;
      f = flags;
      if (to_user) begin
         f[FLAG_USER]    = 1'b1;
         f[FLAG_PRESENT] = 1'b1;
      end else begin
         f[FLAG_USER]     = 1'b0;
         f[FLAG_PRESENT]  = 1'b1;
         f[FLAG_WRITABLE] = 1'b1;
      end
      return f;
   endfunction

endpackage

// File: hw/rtl/ppru_ram.sv
// ----------------------------------------------------------------------------
// ppru_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ppru_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/ppru_range.sv
// ----------------------------------------------------------------------------
// ppru_range
// two-stage page range calculation: round outward, clamp, count
// ----------------------------------------------------------------------------
module ppru_range #(
   parameter int NUM_TABLES = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  ppru_pkg::op_type                op,
   input  logic [ppru_pkg::ADDR_W-1:0]     addr,
   input  logic [ppru_pkg::ADDR_W-1:0]     size,
   output logic                            plan_valid,
   output ppru_pkg::plan_type              plan
);

   localparam int TOTAL_PAGES = NUM_TABLES * ppru_pkg::ENTRIES_PER_TABLE;
   localparam int EW          = ppru_pkg::PAGE_NUM_W + 1;
   localparam logic [EW-1:0] TotalPagesW = EW'(TOTAL_PAGES);

   logic                                s1_valid_ff;
   ppru_pkg::op_type                    s1_op_ff;
   logic [ppru_pkg::PAGE_NUM_W-1:0]     s1_first_ff;
   logic [EW-1:0]                       s1_end_ff;
   logic [ppru_pkg::ADDR_W:0]           end_sum;

   logic                                plan_valid_ff;
   ppru_pkg::plan_type                  plan_ff;
   ppru_pkg::plan_type                  plan_in;
   logic [EW-1:0]                       last_pg;
   logic [EW-1:0]                       first_w;
   logic [EW-1:0]                       diff;

   // end of range rounded up to a page bound
   assign end_sum = {1'b0, addr} + {1'b0, size} + (ppru_pkg::ADDR_W+1)'(12'hFFF);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
      if (start) begin
         s1_op_ff    <= op;
         s1_first_ff <= addr[ppru_pkg::ADDR_W-1:12];
         s1_end_ff   <= end_sum[ppru_pkg::ADDR_W:12];
      end
   end

   always_comb begin
      first_w = {1'b0, s1_first_ff};
      last_pg = (s1_end_ff > TotalPagesW) ? TotalPagesW : s1_end_ff;
      diff    = last_pg - first_w;
      plan_in.op       = s1_op_ff;
      plan_in.empty    = (first_w >= last_pg);
      plan_in.in_range = (first_w < TotalPagesW);
      plan_in.first    = s1_first_ff[ppru_pkg::PAGE_IDX_MAX_W-1:0];
      plan_in.count    = diff[ppru_pkg::PAGE_CNT_MAX_W-1:0];
      if (plan_in.empty) begin
         plan_in.pages = '0;
      end else if (diff > EW'(ppru_pkg::PAGES_SAT)) begin
         plan_in.pages = ppru_pkg::PAGES_SAT;
      end else begin
         plan_in.pages = diff[ppru_pkg::PAGES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plan_valid_ff <= 1'b0;
      end else begin
         plan_valid_ff <= s1_valid_ff;
      end
      if (s1_valid_ff) begin
         plan_ff <= plan_in;
      end
   end

   assign plan_valid = plan_valid_ff;
   assign plan       = plan_ff;

endmodule

// File: hw/rtl/ppru_ctrl.sv
// ----------------------------------------------------------------------------
// ppru_ctrl
// flag table sequencer: init sweep, per-page read-modify-write, entry read
// ----------------------------------------------------------------------------
`include "page_permission_region_update_macros.svh"

module ppru_ctrl #(
   parameter int NUM_TABLES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                plan_valid,
   input  ppru_pkg::plan_type  plan,
   input  logic                res_ready,
   output logic                idle,
   output logic                res_valid,
   output ppru_pkg::rsp_type   res
);

   localparam int TOTAL_PAGES = NUM_TABLES * ppru_pkg::ENTRIES_PER_TABLE;
   localparam int AW          = $clog2(TOTAL_PAGES);
   localparam int CW          = $clog2(TOTAL_PAGES + 1);
   localparam logic [AW-1:0] LastIdx   = AW'(TOTAL_PAGES - 1);
   localparam logic [AW-1:0] UserFloor = AW'(ppru_pkg::USER_FLOOR_PAGE);

   typedef enum logic [6:0] {
      ST_INIT   = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_PLAN   = 7'b0000100,
      ST_WALK   = 7'b0001000,
      ST_DRAIN  = 7'b0010000,
      ST_RDWAIT = 7'b0100000,
      ST_REPLY  = 7'b1000000
   } state_type;

   state_type                      state_ff, state_in;
   logic [AW-1:0]                  cursor_ff, cursor_in;
   logic [CW-1:0]                  remain_ff, remain_in;
   ppru_pkg::op_type               op_ff, op_in;
   ppru_pkg::rsp_type              res_ff, res_in;
   logic                           pend_ff, pend_in;
   logic [AW-1:0]                  pend_idx_ff, pend_idx_in;

   logic                           wr_en;
   logic [AW-1:0]                  wr_addr;
   logic [ppru_pkg::FLAGS_W-1:0]   wr_data;
   logic                           rd_en;
   logic [AW-1:0]                  rd_addr;
   logic [ppru_pkg::FLAGS_W-1:0]   rd_data;

   ppru_ram #(
      .WIDTH (ppru_pkg::FLAGS_W),
      .DEPTH (TOTAL_PAGES)
   ) u_flags (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      cursor_in   = cursor_ff;
      remain_in   = remain_ff;
      op_in       = op_ff;
      res_in      = res_ff;
      pend_in     = 1'b0;
      pend_idx_in = cursor_ff;
      rd_en       = 1'b0;
      rd_addr     = cursor_ff;
      // write-back of the page read in the previous cycle
      wr_en       = pend_ff;
      wr_addr     = pend_idx_ff;
      wr_data     = ppru_pkg::flags_update(rd_data, op_ff == ppru_pkg::OP_MARK_USER);

      unique case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = cursor_ff;
            wr_data = '0;
            wr_data[ppru_pkg::FLAG_PRESENT]  = 1'b1;
            wr_data[ppru_pkg::FLAG_WRITABLE] = 1'b1;
            wr_data[ppru_pkg::FLAG_USER]     = (cursor_ff >= UserFloor);
            if (cursor_ff == LastIdx) begin
               cursor_in = '0;
               state_in  = ST_IDLE;
            end else begin
               cursor_in = cursor_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            if (plan_valid) begin
               op_in  = plan.op;
               res_in = '0;
               unique case (plan.op)
                  ppru_pkg::OP_MARK_USER,
                  ppru_pkg::OP_MARK_SUPER: begin
                     res_in.pages_touched = plan.pages;
                     if (plan.empty) begin
                        state_in = ST_REPLY;
                     end else begin
                        cursor_in = plan.first[AW-1:0];
                        remain_in = plan.count[CW-1:0];
                        state_in  = ST_WALK;
                     end
                  end
                  ppru_pkg::OP_READ: begin
                     if (plan.in_range) begin
                        rd_en   = 1'b1;
                        rd_addr = plan.first[AW-1:0];
                        res_in.entry_value = {plan.first[11:0], 12'h000};
                        res_in.in_range    = 1'b1;
                        state_in = ST_RDWAIT;
                     end else begin
                        state_in = ST_REPLY;
                     end
                  end
                  ppru_pkg::OP_RSVD: begin
                     state_in = ST_REPLY;
                  end
                  default: begin
                     state_in = ST_REPLY;
                  end
               endcase
            end
         end
         ST_WALK: begin
            // one page issued per cycle; its write lands the next cycle
            rd_en       = 1'b1;
            rd_addr     = cursor_ff;
            pend_in     = 1'b1;
            pend_idx_in = cursor_ff;
            cursor_in   = cursor_ff + 1'b1;
            remain_in   = remain_ff - 1'b1;
            if (remain_ff == CW'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cursor_in = '0;
            state_in  = ST_REPLY;
         end
         ST_RDWAIT: begin
            res_in.entry_value[ppru_pkg::FLAGS_W-1:0] = rd_data;
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_INIT;
         cursor_ff <= '0;
         remain_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         remain_ff <= remain_in;
         pend_ff   <= pend_in;
      end
      op_ff       <= op_in;
      res_ff      <= res_in;
      pend_idx_ff <= pend_idx_in;
   end

   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_REPLY);
   assign res       = res_ff;

   `PPRU_ASSERT_ALWAYS(a_no_same_entry, clock, reset, rd_en && wr_en, rd_addr != wr_addr)
   `PPRU_ASSERT_ALWAYS(a_idle_clean, clock, reset, state_ff == ST_IDLE, cursor_ff == '0 && !pend_ff)
   `PPRU_ASSERT_ALWAYS(a_pend_in_walk, clock, reset, pend_ff, state_ff == ST_WALK || state_ff == ST_DRAIN)

endmodule

// File: hw/rtl/page_permission_region_update.sv
// ----------------------------------------------------------------------------
// page_permission_region_update
// per-page present/writable/user flags of an identity-mapped region
// ----------------------------------------------------------------------------
// Holds one flag triple (present bit0, writable bit1, user bit2) for each 4 KiB
// page of a NUM_TABLES x 2 MiB identity-mapped region, in a single ram. After
// reset an init sweep writes every entry (present and writable, plus user at
// or above 1 MiB), one entry per cycle, and the block takes no request until
// the sweep is done. Requests are handled one at a time. A region command
// covering n in-table pages passes through the range arithmetic, then one
// read-modify-write per page through the ram's read and write ports, then
// a drain of the last write-back before its response. A read passes through
// the range arithmetic and one ram read, and a region with no pages in the
// table or an unused op goes from the range arithmetic to the response.
// The response sits in an output register, so the next request is taken while
// a finished response still waits on rsp_tready.
// ----------------------------------------------------------------------------
`include "page_permission_region_update_macros.svh"

module page_permission_region_update #(
   parameter int NUM_TABLES = 8
) (
   input  logic          clock,
   input  logic          reset,
   // request channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [95:0]   req_tdata,   // [47:0] addr, [95:48] size
   input  logic [1:0]    req_tuser,   // [1:0] op
   // response channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [39:0]   rsp_tdata    // [23:0] entry_value, [24] in_range,
                                      // [37:25] pages_touched, [39:38] zero
);

   logic                 req_accept;
   logic                 ctrl_idle;
   logic                 plan_valid;
   ppru_pkg::plan_type   plan;
   logic                 res_valid;
   logic                 res_ready;
   ppru_pkg::rsp_type    res;

   logic                 rsp_valid_ff, rsp_valid_in;
   ppru_pkg::rsp_type    rsp_data_ff;

   assign req_tready = ctrl_idle;
   assign req_accept = req_tvalid && req_tready;

   // page bounds of the request
   ppru_range #(
      .NUM_TABLES (NUM_TABLES)
   ) u_range (
      .clock      (clock),
      .reset      (reset),
      .start      (req_accept),
      .op         (ppru_pkg::op_type'(req_tuser)),
      .addr       (req_tdata[47:0]),
      .size       (req_tdata[95:48]),
      .plan_valid (plan_valid),
      .plan       (plan)
   );

   // table sweep and per-page update
   ppru_ctrl #(
      .NUM_TABLES (NUM_TABLES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (req_accept),
      .plan_valid (plan_valid),
      .plan       (plan),
      .res_ready  (res_ready),
      .idle       (ctrl_idle),
      .res_valid  (res_valid),
      .res        (res)
   );

   // output register: free when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_valid && res_ready) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

   // one request in flight: a taken request closes the input until it is done
   `PPRU_ASSERT_NEXT(a_one_in_flight, clock, reset, req_accept, !req_tready)

endmodule
